[rtl/core/epsl_pkg.sv]
// Shared types, codes and constants of the encoder position speed loop.
package epsl_pkg;

   typedef logic [1:0] op_type;

   localparam op_type OP_EDGE  = 2'd0;
   localparam op_type OP_TICK  = 2'd1;
   localparam op_type OP_SPEED = 2'd2;
   localparam op_type OP_CLEAR = 2'd3;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_GAIN           = 3'd0;
   localparam csr_index_type CSR_SPEED_LIMIT    = 3'd1;
   localparam csr_index_type CSR_PERIOD_TICKS   = 3'd2;
   localparam csr_index_type CSR_MOTOR_INVERT   = 3'd3;
   localparam csr_index_type CSR_ENCODER_INVERT = 3'd4;

   typedef struct packed {
      logic [7:0]  gain;
      logic [14:0] speed_limit;
      logic [15:0] period_ticks;
      logic        motor_invert;
      logic        encoder_invert;
   } cfg_type;

   localparam logic [7:0]  GAIN_RESET   = 8'd1;
   localparam logic [14:0] LIMIT_RESET  = 15'd32767;
   localparam logic [15:0] PERIOD_RESET = 16'd10;

   localparam int DRIVE_LIMIT = 255;

   typedef logic signed [8:0] drive_err_type;

   typedef struct packed {
      logic          valid;
      drive_err_type err;
   } stage_type;

endpackage

[rtl/core/epsl_csr.sv]
// Configuration register file with write decode.
module epsl_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  epsl_pkg::csr_index_type        csr_index,
   input  logic [epsl_pkg::CSR_DATA_W-1:0] csr_wdata,
   output epsl_pkg::cfg_type              cfg
);
   import epsl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAIN:           cfg_in.gain           = csr_wdata[7:0];
            CSR_SPEED_LIMIT:    cfg_in.speed_limit    = csr_wdata[14:0];
            CSR_PERIOD_TICKS:   cfg_in.period_ticks   = csr_wdata[15:0];
            CSR_MOTOR_INVERT:   cfg_in.motor_invert   = csr_wdata[0];
            CSR_ENCODER_INVERT: cfg_in.encoder_invert = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain           <= GAIN_RESET;
         cfg_ff.speed_limit    <= LIMIT_RESET;
         cfg_ff.period_ticks   <= PERIOD_RESET;
         cfg_ff.motor_invert   <= 1'b0;
         cfg_ff.encoder_invert <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/epsl_state.sv]
// Loop state update and clipped position error stage.
module epsl_state #(
   parameter int POS_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  epsl_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  epsl_pkg::op_type    req_op,
   input  logic                req_enc_b,
   input  logic signed [15:0]  req_speed,
   input  logic                stage_take,
   output epsl_pkg::stage_type stage
);
   import epsl_pkg::*;

   localparam logic signed [POS_WIDTH-1:0] ERR_HI = POS_WIDTH'(DRIVE_LIMIT);
   localparam logic signed [POS_WIDTH-1:0] ERR_LO = -ERR_HI;

   logic signed [POS_WIDTH-1:0] pos_err_ff, pos_err_in;
   logic signed [15:0]          speed_ff, speed_in;
   logic [15:0]                 count_ff, count_in;
   logic                        valid_ff, valid_in;
   drive_err_type               clip_ff, clip_in;

   logic                        accept;
   logic signed [POS_WIDTH-1:0] step;
   logic signed [POS_WIDTH-1:0] edge_err;
   logic signed [POS_WIDTH-1:0] drive_err;
   logic signed [15:0]          lim;
   logic signed [15:0]          speed_clip;

   assign req_ready = !valid_ff || stage_take;
   assign accept    = req_valid && req_ready;
   assign step      = POS_WIDTH'(speed_ff);
   assign edge_err  = (req_enc_b ^ cfg.encoder_invert) ? pos_err_ff - POS_WIDTH'(1)
                                                      : pos_err_ff + POS_WIDTH'(1);
   assign lim       = $signed({1'b0, cfg.speed_limit});

   always_comb begin
      if (req_speed > lim) begin
         speed_clip = lim;
      end else if (req_speed < -lim) begin
         speed_clip = -lim;
      end else begin
         speed_clip = req_speed;
      end
   end

   always_comb begin
      pos_err_in = pos_err_ff;
      speed_in   = speed_ff;
      count_in   = count_ff;
      drive_err  = pos_err_ff;
      if (accept) begin
         unique case (req_op)
            OP_EDGE: begin
               pos_err_in = edge_err;
               drive_err  = edge_err;
            end
            OP_TICK: begin
               if (count_ff == 16'd0) begin
                  count_in   = cfg.period_ticks;
                  pos_err_in = pos_err_ff + step;
               end else begin
                  count_in = count_ff - 16'd1;
               end
            end
            OP_SPEED: begin
               speed_in = speed_clip;
            end
            OP_CLEAR: begin
               pos_err_in = '0;
               speed_in   = '0;
               count_in   = '0;
               drive_err  = '0;
            end
            default: begin
               pos_err_in = pos_err_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (drive_err > ERR_HI) begin
         clip_in = drive_err_type'(DRIVE_LIMIT);
      end else if (drive_err < ERR_LO) begin
         clip_in = -drive_err_type'(DRIVE_LIMIT);
      end else begin
         clip_in = drive_err[8:0];
      end
   end

   assign valid_in = accept ? 1'b1 : (stage_take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_err_ff <= '0;
         speed_ff   <= '0;
         count_ff   <= '0;
         valid_ff   <= 1'b0;
      end else begin
         pos_err_ff <= pos_err_in;
         speed_ff   <= speed_in;
         count_ff   <= count_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         clip_ff <= clip_in;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.err   = clip_ff;

   a_clip_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (clip_ff != -drive_err_type'(DRIVE_LIMIT + 1)))
      else $error("clipped error out of range");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_CLEAR) |=>
         (pos_err_ff == '0 && speed_ff == '0 && count_ff == '0))
      else $error("clear item left loop state");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(pos_err_ff) && $stable(speed_ff) && $stable(count_ff)))
      else $error("loop state moved without a word");

endmodule

[rtl/core/epsl_drive.sv]
// Gain multiply, drive saturation and result register.
module epsl_drive (
   input  logic                clock,
   input  logic                reset,
   input  epsl_pkg::cfg_type   cfg,
   input  epsl_pkg::stage_type stage,
   output logic                stage_take,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_reverse,
   output logic [7:0]          rsp_pwm
);
   import epsl_pkg::*;

   localparam logic signed [17:0] PROD_HI = 18'(DRIVE_LIMIT);
   localparam logic signed [17:0] PROD_LO = -PROD_HI;

   logic signed [8:0]  gain_s;
   logic signed [17:0] prod;
   drive_err_type      drive;
   drive_err_type      mag;

   logic       valid_ff, valid_in;
   logic       reverse_ff;
   logic [7:0] pwm_ff;

   assign gain_s = $signed({1'b0, cfg.gain});
   assign prod   = gain_s * stage.err;

   always_comb begin
      if (prod > PROD_HI) begin
         drive = drive_err_type'(DRIVE_LIMIT);
      end else if (prod < PROD_LO) begin
         drive = -drive_err_type'(DRIVE_LIMIT);
      end else begin
         drive = prod[8:0];
      end
   end

   assign mag = drive[8] ? -drive : drive;

   assign stage_take = stage.valid && (!valid_ff || rsp_ready);
   assign valid_in   = stage_take ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_take) begin
         reverse_ff <= drive[8] ^ cfg.motor_invert;
         pwm_ff     <= mag[7:0];
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_reverse = reverse_ff;
   assign rsp_pwm     = pwm_ff;

   a_zero_gain: assert property (@(posedge clock) disable iff (reset)
      (stage_take && cfg.gain == 8'd0) |=> (rsp_pwm == 8'd0))
      else $error("zero gain gave nonzero drive");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      stage_take |=> rsp_valid)
      else $error("stage word lost on the way to the result register");

endmodule

[rtl/core/encoder_position_speed_loop_top.sv]
// A word accepted is registered in the error stage, moves on to the result register
// when the drive side takes it, and can then be taken by the result side.
// Throughput: one word per cycle; ready drops only when the result register
// and the error stage both hold words that the result side has not taken.
// Reset clears the loop state, the pipeline valid bits and loads the register
// reset values; the block takes words in the first cycle after reset.
module encoder_position_speed_loop_top #(
   parameter int POS_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  epsl_pkg::op_type                req_op,
   input  logic                            req_enc_b,
   input  logic signed [15:0]              req_speed,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_reverse,
   output logic [7:0]                      rsp_pwm,
   input  logic                            csr_wr_en,
   input  epsl_pkg::csr_index_type         csr_index,
   input  logic [epsl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import epsl_pkg::*;

   cfg_type   cfg;
   stage_type stage;
   logic      stage_take;

   epsl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   epsl_state #(
      .POS_WIDTH (POS_WIDTH)
   ) u_state (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_enc_b  (req_enc_b),
      .req_speed  (req_speed),
      .stage_take (stage_take),
      .stage      (stage)
   );

   epsl_drive u_drive (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage       (stage),
      .stage_take  (stage_take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_reverse (rsp_reverse),
      .rsp_pwm     (rsp_pwm)
   );

endmodule

[dv/encoder_position_speed_loop_top_test.sv]
// Testbench for encoder_position_speed_loop_top: predicts every result word and checks it.
`timescale 1ns / 100ps

module encoder_position_speed_loop_top_test;
   import epsl_pkg::*;

   localparam int POS_W       = 32;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct {
      op_type             op;
      logic               enc_b;
      logic signed [15:0] speed;
   } loop_cmd_type;

   typedef struct {
      logic       reverse;
      logic [7:0] pwm;
   } drive_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   op_type                req_op = OP_EDGE;
   logic                  req_enc_b = 1'b0;
   logic signed [15:0]    req_speed = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_reverse;
   logic [7:0]            rsp_pwm;
   logic                  csr_wr_en = 1'b0;
   csr_index_type         csr_index = CSR_GAIN;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   loop_cmd_type   cmd_pending_q[$];
   drive_word_type drive_expect_q[$];
   loop_cmd_type   cur_cmd;

   // predicted loop state and register copy
   cfg_type                  cfg_copy;
   logic [POS_W-1:0]         pos_count;
   logic [POS_W-1:0]         target_pos;
   logic signed [15:0]       speed_step;
   logic [15:0]              countdown;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches = 0;
   int words_sent = 0;
   int words_checked = 0;
   int settings_used = 0;
   int cycle_count = 0;

   encoder_position_speed_loop_top #(.POS_WIDTH(POS_W)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_enc_b   (req_enc_b),
      .req_speed   (req_speed),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_reverse (rsp_reverse),
      .rsp_pwm     (rsp_pwm),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int drive_from_error();
      logic signed [POS_W-1:0] err;
      int g;
      int d;
      err = target_pos - pos_count;
      g = cfg_copy.gain;
      if (g == 0) return 0;
      if (err > 255) return 255;
      if (err < -255) return -255;
      d = g * int'(err);
      if (d > DRIVE_LIMIT) d = DRIVE_LIMIT;
      if (d < -DRIVE_LIMIT) d = -DRIVE_LIMIT;
      return d;
   endfunction

   function automatic void predict_drive_word(loop_cmd_type c);
      int                      drive;
      int                      s;
      int                      lim;
      logic signed [POS_W-1:0] step_ext;
      drive_word_type          w;
      case (c.op)
         OP_EDGE: begin
            if (c.enc_b ^ cfg_copy.encoder_invert) pos_count = pos_count + 1'b1;
            else pos_count = pos_count - 1'b1;
            drive = drive_from_error();
         end
         OP_TICK: begin
            drive = drive_from_error();
            if (countdown == 0) begin
               countdown = cfg_copy.period_ticks;
               step_ext = speed_step;
               target_pos = target_pos + step_ext;
            end else begin
               countdown = countdown - 1'b1;
            end
         end
         OP_SPEED: begin
            s = c.speed;
            lim = cfg_copy.speed_limit;
            if (s > lim) s = lim;
            if (s < -lim) s = -lim;
            speed_step = 16'(s);
            drive = drive_from_error();
         end
         default: begin
            pos_count = '0;
            target_pos = '0;
            speed_step = '0;
            countdown = '0;
            drive = drive_from_error();
         end
      endcase
      w.reverse = (drive < 0) ^ cfg_copy.motor_invert;
      w.pwm = 8'(drive < 0 ? -drive : drive);
      drive_expect_q.push_back(w);
   endfunction

   // driver: present pending words, predict each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_drive_word(cur_cmd);
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (cmd_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_cmd = cmd_pending_q.pop_front();
               req_valid <= 1'b1;
               req_op <= cur_cmd.op;
               req_enc_b <= cur_cmd.enc_b;
               req_speed <= cur_cmd.speed;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: stall at random, compare each result word with the oldest prediction
   always @(posedge clock) begin
      drive_word_type want;
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (drive_expect_q.size() == 0) begin
            $error("unexpected result word: reverse %0d pwm %0d", rsp_reverse, rsp_pwm);
            mismatches++;
         end else begin
            want = drive_expect_q.pop_front();
            if (rsp_reverse !== want.reverse) begin
               $error("reverse mismatch: expected %0d, got %0d", want.reverse, rsp_reverse);
               mismatches++;
            end
            if (rsp_pwm !== want.pwm) begin
               $error("pwm mismatch: expected %0d, got %0d", want.pwm, rsp_pwm);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("encoder_position_speed_loop_top_test: errors");
         $finish;
      end
   end

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_GAIN:           cfg_copy.gain = data[7:0];
         CSR_SPEED_LIMIT:    cfg_copy.speed_limit = data[14:0];
         CSR_PERIOD_TICKS:   cfg_copy.period_ticks = data[15:0];
         CSR_MOTOR_INVERT:   cfg_copy.motor_invert = data[0];
         CSR_ENCODER_INVERT: cfg_copy.encoder_invert = data[0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_settings(int gain, int limit, int period, int minv, int einv);
      write_register(CSR_GAIN, 16'(gain));
      write_register(CSR_SPEED_LIMIT, 16'(limit));
      write_register(CSR_PERIOD_TICKS, 16'(period));
      write_register(CSR_MOTOR_INVERT, 16'(minv));
      write_register(CSR_ENCODER_INVERT, 16'(einv));
      settings_used++;
   endtask

   task automatic push_cmd(op_type op, logic b, logic signed [15:0] spd);
      loop_cmd_type c;
      c.op = op;
      c.enc_b = b;
      c.speed = spd;
      cmd_pending_q.push_back(c);
   endtask

   task automatic drain_loop();
      while (cmd_pending_q.size() != 0 || req_valid || drive_expect_q.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic loop_cmd_type random_cmd();
      loop_cmd_type c;
      int r;
      r = $urandom_range(99);
      if (r < 42) c.op = OP_EDGE;
      else if (r < 78) c.op = OP_TICK;
      else if (r < 96) c.op = OP_SPEED;
      else c.op = OP_CLEAR;
      c.enc_b = $urandom_range(1);
      r = $urandom_range(99);
      if (r < 70) c.speed = 16'($urandom_range(40) - 20);
      else if (r < 85) c.speed = 16'($urandom);
      else begin
         case ($urandom_range(3))
            0: c.speed = 16'sh7FFF;
            1: c.speed = 16'sh8000;
            2: c.speed = 16'sh0000;
            default: c.speed = 16'shFFFF;
         endcase
      end
      return c;
   endfunction

   task automatic run_random_phase(int gain, int limit, int period, int minv, int einv,
                                   int send_pct, int stall_pct, int count);
      load_settings(gain, limit, period, minv, einv);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      push_cmd(OP_CLEAR, 1'b0, 16'sd0);
      for (int i = 0; i < count; i++) cmd_pending_q.push_back(random_cmd());
      drain_loop();
   endtask

   initial begin
      cfg_copy.gain = GAIN_RESET;
      cfg_copy.speed_limit = LIMIT_RESET;
      cfg_copy.period_ticks = PERIOD_RESET;
      cfg_copy.motor_invert = 1'b0;
      cfg_copy.encoder_invert = 1'b0;
      pos_count = '0;
      target_pos = '0;
      speed_step = '0;
      countdown = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: counting, clamp at full limit, tick ordering
      push_cmd(OP_CLEAR, 1'b1, 16'sh7FFF);
      push_cmd(OP_EDGE, 1'b1, 16'sd0);
      push_cmd(OP_EDGE, 1'b0, 16'sd0);
      push_cmd(OP_EDGE, 1'b0, 16'sh8000);
      push_cmd(OP_SPEED, 1'b0, 16'sh7FFF);
      push_cmd(OP_SPEED, 1'b1, 16'sh8000);
      push_cmd(OP_SPEED, 1'b0, 16'sd5);
      push_cmd(OP_TICK, 1'b0, 16'sd0);
      push_cmd(OP_TICK, 1'b1, 16'shFFFF);
      push_cmd(OP_CLEAR, 1'b0, 16'sd0);
      drain_loop();

      // masked writes, ignored indexes, both inverts, small limit
      write_register(CSR_GAIN, 16'hAB03);
      write_register(CSR_SPEED_LIMIT, 16'h8004);
      write_register(CSR_PERIOD_TICKS, 16'h0000);
      write_register(CSR_MOTOR_INVERT, 16'hFFFF);
      write_register(CSR_ENCODER_INVERT, 16'h0003);
      write_register(csr_index_type'(5), 16'hFFFF);
      write_register(csr_index_type'(7), 16'h5A5A);
      settings_used++;
      push_cmd(OP_EDGE, 1'b1, 16'sd0);
      push_cmd(OP_SPEED, 1'b0, 16'sd300);
      push_cmd(OP_TICK, 1'b0, 16'sd0);
      push_cmd(OP_TICK, 1'b0, 16'sd0);
      push_cmd(OP_TICK, 1'b0, 16'sd0);
      push_cmd(OP_EDGE, 1'b0, 16'sd0);
      push_cmd(OP_SPEED, 1'b1, 16'sh8000);
      push_cmd(OP_TICK, 1'b1, 16'sd0);
      push_cmd(OP_TICK, 1'b1, 16'sd0);
      push_cmd(OP_CLEAR, 1'b1, 16'shFFFF);
      drain_loop();

      // drive the target far past the saturation range with full-size steps
      load_settings(1, 32767, 0, 0, 0);
      push_cmd(OP_CLEAR, 1'b0, 16'sd0);
      push_cmd(OP_SPEED, 1'b0, 16'sh7FFF);
      for (int i = 0; i < 100; i++) push_cmd(OP_TICK, 1'b0, 16'sd0);
      drain_loop();

      run_random_phase(1, 32767, 0, 0, 0, 0, 0, 280);
      run_random_phase(255, 0, 3, 1, 0, 62, 0, 280);
      run_random_phase(0, 20, 1, 0, 1, 0, 62, 280);
      run_random_phase(3, 12, 65535, 1, 1, 23, 23, 280);
      run_random_phase($urandom_range(1, 16), $urandom_range(40), $urandom_range(5),
                       $urandom_range(1), $urandom_range(1), 0, 0, 280);
      run_random_phase($urandom_range(255), $urandom_range(32767), $urandom_range(3),
                       $urandom_range(1), $urandom_range(1), 23, 23, 280);

      $display("%0d words sent and %0d result words checked over %0d register settings,",
               words_sent, words_checked, settings_used);
      $display("including masked and ignored register writes and a long run of big target steps");
      if (mismatches == 0 && drive_expect_q.size() == 0) begin
         $display("encoder_position_speed_loop_top_test: clean");
      end else begin
         $display("encoder_position_speed_loop_top_test: errors");
      end
      $finish;
   end

endmodule
